>>> hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, tables and byte-level functions of the AES-256 engine.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NumRounds = 14;
    localparam int NumCols = 4;

    typedef logic [7:0] byte_t;
    typedef logic [31:0] col_t;
    typedef logic [127:0] blk_t;

    typedef enum logic [1:0] {
        KEY_WORD_0 = 2'd0,
        KEY_WORD_1 = 2'd1,
        KEY_WORD_2 = 2'd2,
        KEY_WORD_3 = 2'd3
    } key_idx_t;

    // Control handed from the round sequencer to each column cell.
    typedef struct packed {
        logic load;
        logic dec;
        logic last;
    } cell_ctrl_t;

    function automatic byte_t xt(input byte_t a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t sbox(input byte_t x);
        logic [7:0] t [256];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        sbox = t[x];
    endfunction

    function automatic byte_t inv_sbox(input byte_t x);
        logic [7:0] t [256];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        inv_sbox = t[x];
    endfunction

    function automatic col_t sub_word(input col_t w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic col_t mix_col(input col_t c);
        byte_t a0, a1, a2, a3;
        a0 = c[31:24];
        a1 = c[23:16];
        a2 = c[15:8];
        a3 = c[7:0];
        mix_col = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                   a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                   a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                   xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    // InvMixColumns as a pre-step (multiply by {05,00,04,00}) followed by MixColumns.
    function automatic col_t inv_mix_col(input col_t c);
        byte_t a0, a1, a2, a3, u, v;
        a0 = c[31:24];
        a1 = c[23:16];
        a2 = c[15:8];
        a3 = c[7:0];
        u = xt(xt(a0 ^ a2));
        v = xt(xt(a1 ^ a3));
        inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

    function automatic byte_t rcon(input logic [2:0] i);
        byte_t r;
        unique case (i)
            3'd1: r = 8'h01;
            3'd2: r = 8'h02;
            3'd3: r = 8'h04;
            3'd4: r = 8'h08;
            3'd5: r = 8'h10;
            3'd6: r = 8'h20;
            3'd7: r = 8'h40;
            default: r = 8'h00;
        endcase
        rcon = r;
    endfunction

endpackage

>>> hw/rtl/aes256_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-256 block cipher
// Encrypts or decrypts one 128-bit block with a 256-bit key, one round a cycle.
// ----------------------------------------------------------------------------
// Channel  | Signals                               | Flow
// input    | start, busy, op, block_high/low       | start taken when busy is low
// result   | done, out_high, out_low               | one-cycle strobe, no stall
// key      | cfg_we, cfg_idx, cfg_data             | write per edge, no wait
//
// A block passes through the row of four column cells, one round a cycle;
// done rises with the result of the last round. After reset or a key write
// busy stays high until the key expander is done. Results cannot be stalled.
// ----------------------------------------------------------------------------
module aes256_block_cipher
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        done,
    output logic [63:0] out_high,
    output logic [63:0] out_low
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t       state_reg;
    logic [3:0]   rnd_reg;
    logic         dec_reg;
    logic         done_reg;
    logic         kick_reg;
    logic [255:0] key_reg;
    logic         keys_ready;
    logic [3:0]   rd_round;
    blk_t         rk;
    blk_t         in_blk;
    cell_ctrl_t   ctrl;
    col_t         cols [NumCols];
    col_t         shifted [NumCols];
    logic         take;

    assign take = start && !busy;
    assign in_blk = {block_high, block_low};
    assign busy = (state_reg == ST_RUN) || !keys_ready || kick_reg;

    always_comb begin
        if (take) begin
            rd_round = op ? 4'(NumRounds) : 4'd0;
        end
        else begin
            rd_round = dec_reg ? 4'(NumRounds) - rnd_reg : rnd_reg;
        end
        ctrl.load  = take;
        ctrl.dec   = dec_reg;
        ctrl.last  = (rnd_reg == 4'(NumRounds));
        // Each cell gets byte r from column (c+r) for encrypt, (c-r) for decrypt.
        for (int c = 0; c < NumCols; c++) begin
            for (int r = 0; r < 4; r++) begin
                shifted[c][31 - 8*r -: 8] = dec_reg
                    ? cols[(c - r + 4) % 4][31 - 8*r -: 8]
                    : cols[(c + r) % 4][31 - 8*r -: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_reg  <= '0;
            kick_reg <= 1'b1;
        end
        else begin
            kick_reg <= 1'b0;
            if (cfg_we) begin
                unique case (key_idx_t'(cfg_idx))
                    KEY_WORD_0: key_reg[255:192] <= cfg_data;
                    KEY_WORD_1: key_reg[191:128] <= cfg_data;
                    KEY_WORD_2: key_reg[127:64]  <= cfg_data;
                    KEY_WORD_3: key_reg[63:0]    <= cfg_data;
                endcase
                kick_reg <= 1'b1;
            end
        end
    end

    aes_key_exp u_key_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (kick_reg),
        .key      (key_reg),
        .rd_round (rd_round),
        .rd_dec   (take ? op : dec_reg),
        .rd_key   (rk),
        .done     (keys_ready)
    );

    for (genvar c = 0; c < NumCols; c++) begin : g_cell
        aes_col_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .load_col (in_blk[127 - 32*c -: 32]),
            .rk       (rk[127 - 32*c -: 32]),
            .shift_in (shifted[c]),
            .col      (cols[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 4'd0;
            dec_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        state_reg <= ST_RUN;
                        rnd_reg   <= 4'd1;
                        dec_reg   <= op;
                    end
                end
                ST_RUN: begin
                    if (rnd_reg == 4'(NumRounds)) begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else begin
                        rnd_reg <= rnd_reg + 4'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign out_high = {cols[0], cols[1]};
    assign out_low  = {cols[2], cols[3]};

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_RUN))
        else $error("done without a finishing round");

    a_no_take_when_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> busy)
        else $error("not busy while running");

    a_run_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg == ST_RUN)
        else $error("start not taken");

endmodule

>>> hw/rtl/aes_key_exp.sv
// ----------------------------------------------------------------------------
// AES key expansion
// Expands the 256-bit key into fifteen round keys, one 128-bit key a cycle.
// ----------------------------------------------------------------------------
module aes_key_exp
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restart,
    input  logic [255:0] key,
    input  logic [3:0]  rd_round,
    input  logic        rd_dec,
    output blk_t        rd_key,
    output logic        done
);

    logic [3:0]   cnt_reg;
    logic [255:0] win_reg;
    blk_t         enc_keys_reg [15];
    blk_t         dec_keys_reg [15];
    col_t         w0, w1, w2, w3, t;
    blk_t         nk, nk_dec;

    // The window holds the last eight words; each step appends four more.
    always_comb begin
        if (cnt_reg[0]) begin
            t = sub_word(win_reg[31:0]);
        end
        else begin
            t = sub_word({win_reg[23:0], win_reg[31:24]}) ^
                {rcon(cnt_reg[3:1] + 3'd1), 24'h0};
        end
        w0 = win_reg[255:224] ^ t;
        w1 = win_reg[223:192] ^ w0;
        w2 = win_reg[191:160] ^ w1;
        w3 = win_reg[159:128] ^ w2;
        nk = {w0, w1, w2, w3};
        nk_dec = {inv_mix_col(w0), inv_mix_col(w1), inv_mix_col(w2), inv_mix_col(w3)};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= 4'd0;
            win_reg <= '0;
            for (int i = 0; i < 15; i++) begin
                enc_keys_reg[i] <= '0;
                dec_keys_reg[i] <= '0;
            end
        end
        else if (restart) begin
            cnt_reg <= 4'd0;
            win_reg <= key;
            enc_keys_reg[0] <= key[255:128];
            dec_keys_reg[0] <= key[255:128];
            enc_keys_reg[1] <= key[127:0];
            dec_keys_reg[1] <= {inv_mix_col(key[127:96]), inv_mix_col(key[95:64]),
                                inv_mix_col(key[63:32]), inv_mix_col(key[31:0])};
        end
        else if (cnt_reg != 4'd13) begin
            cnt_reg <= cnt_reg + 4'd1;
            win_reg <= {win_reg[127:0], nk};
            enc_keys_reg[cnt_reg + 4'd2] <= nk;
            dec_keys_reg[cnt_reg + 4'd2] <= nk_dec;
        end
    end

    assign done = (cnt_reg == 4'd13);
    assign rd_key = (rd_dec && rd_round != 4'd0 && rd_round != 4'(NumRounds))
        ? dec_keys_reg[rd_round] : enc_keys_reg[rd_round];

endmodule

>>> hw/rtl/aes_col_cell.sv
// ----------------------------------------------------------------------------
// AES column cell
// Holds one state column and computes its share of a round each cycle.
// ----------------------------------------------------------------------------
module aes_col_cell
    import aes_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  col_t       load_col,
    input  col_t       rk,
    input  col_t       shift_in,
    output col_t       col
);

    col_t col_reg, sub, mixed;

    // shift_in carries the column bytes already moved across by ShiftRows or InvShiftRows.
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            sub[31 - 8*b -: 8] = ctrl.dec ? inv_sbox(shift_in[31 - 8*b -: 8])
                                          : sbox(shift_in[31 - 8*b -: 8]);
        end
        if (ctrl.last) begin
            mixed = sub;
        end
        else if (ctrl.dec) begin
            mixed = inv_mix_col(sub);
        end
        else begin
            mixed = mix_col(sub);
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.load) begin
            col_reg <= load_col ^ rk;
        end
        else begin
            col_reg <= mixed ^ rk;
        end
    end

    assign col = col_reg;

endmodule

>>> tb/sv/aes_tb_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 testbench package
// Operation codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package aes_tb_pkg;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

endpackage

>>> tb/sv/aes256_checker.sv
// ----------------------------------------------------------------------------
// AES-256 result checker
// Follows key writes and accepted blocks, computes the expected cipher
// output from its own AES-256 implementation and compares every result word.
// ----------------------------------------------------------------------------
module aes256_checker
    import aes_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [63:0] cfg_data,
    input  logic        start,
    input  logic        busy,
    input  logic        op,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        done,
    input  logic [63:0] out_high,
    input  logic [63:0] out_low,
    output int          errors,
    output int          pending,
    output int          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]   fwd_sub [256];
    logic [7:0]   rev_sub [256];
    logic [63:0]  key_reg [4];
    logic [127:0] round_key [15];
    logic [127:0] expected_words [$];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [31:0] sub_col(input logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    function automatic void expand_key();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            w[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i - 1];
            if (i % 8 == 0)
            begin
                t = sub_col({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = {rc[6:0], 1'b0};
            end
            else if (i % 8 == 4)
                t = sub_col(t);
            w[i] = w[i - 8] ^ t;
        end
        for (int r = 0; r < 15; r++)
            round_key[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    endfunction

    function automatic logic [127:0] run_cipher(input logic dec, input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        int r;
        for (int i = 0; i < 16; i++)
            s[i] = blk[127 - 8 * i -: 8];
        for (int step = 0; step <= 14; step++)
        begin
            r = dec ? 14 - step : step;
            if (step > 0)
            begin
                for (int row = 0; row < 4; row++)
                    for (int c = 0; c < 4; c++)
                        if (dec)
                            t[row + 4 * ((c + row) % 4)] = rev_sub[s[row + 4 * c]];
                        else
                            t[row + 4 * c] = fwd_sub[s[row + 4 * ((c + row) % 4)]];
                s = t;
            end
            if (step > 0 && step < 14 && !dec)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                    s[4 * c]     = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
                    s[4 * c + 1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
                    s[4 * c + 2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
                    s[4 * c + 3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
                end
            for (int i = 0; i < 16; i++)
                s[i] ^= round_key[r][127 - 8 * i -: 8];
            if (step > 0 && step < 14 && dec)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                    s[4 * c]     = gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b)
                                 ^ gf_mul(a2, 8'h0d) ^ gf_mul(a3, 8'h09);
                    s[4 * c + 1] = gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0e)
                                 ^ gf_mul(a2, 8'h0b) ^ gf_mul(a3, 8'h0d);
                    s[4 * c + 2] = gf_mul(a0, 8'h0d) ^ gf_mul(a1, 8'h09)
                                 ^ gf_mul(a2, 8'h0e) ^ gf_mul(a3, 8'h0b);
                    s[4 * c + 3] = gf_mul(a0, 8'h0b) ^ gf_mul(a1, 8'h0d)
                                 ^ gf_mul(a2, 8'h09) ^ gf_mul(a3, 8'h0e);
                end
        end
        for (int i = 0; i < 16; i++)
            blk[127 - 8 * i -: 8] = s[i];
        return blk;
    endfunction

    initial
    begin
        logic [7:0] inv, b;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h01;
            repeat (254) inv = gf_mul(inv, x[7:0]);
            if (x == 0)
                inv = 8'h00;
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[x] = b;
        end
        for (int x = 0; x < 256; x++)
            rev_sub[fwd_sub[x]] = x[7:0];
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] = 64'h0;
            expand_key();
            expected_words.delete();
            errors = 0;
            checked = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                key_reg[cfg_idx] = cfg_data;
                expand_key();
            end
            if (start && !busy)
                expected_words.push_back(run_cipher(op == OP_DECRYPT, {block_high, block_low}));
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word %h %h", out_high, out_low);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    checked++;
                    if (out_high !== want[127:64])
                    begin
                        $error("out_high expected %h actual %h", want[127:64], out_high);
                        errors++;
                    end
                    if (out_low !== want[63:0])
                    begin
                        $error("out_low expected %h actual %h", want[63:0], out_low);
                        errors++;
                    end
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// AES-256 block cipher testbench
// Drives directed and random blocks in both directions under several keys,
// with bursty input timing, and lets the checker compare every result word.
// ----------------------------------------------------------------------------
module testbench
    import aes_pkg::*;
    import aes_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = KEY_WORD_0;
    logic [63:0] cfg_data = 64'h0;
    logic        start = 1'b0;
    logic        op = OP_ENCRYPT;
    logic [63:0] block_high = 64'h0;
    logic [63:0] block_low = 64'h0;
    logic        busy, done;
    logic [63:0] out_high, out_low;
    int          errors, pending, checked;
    int          cycles = 0;
    int          key_writes = 0;
    int          burst_left = 0;

    always #10 clk = ~clk;

    aes256_block_cipher DUT (.*);

    aes256_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_key(input key_idx_t idx, input logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        key_writes++;
    endtask

    task automatic send_word(input logic dir, input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        start <= 1'b1;
        op <= dir;
        block_high <= hi;
        block_low <= lo;
        do
            @(posedge clk);
        while (busy);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(20, 60);
            gap = $urandom_range(1, 25);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [63:0] hi, lo;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_ENCRYPT, 64'h0, 64'h0);
        send_word(OP_DECRYPT, 64'h0, 64'h0);
        send_word(OP_ENCRYPT, '1, '1);
        send_word(OP_DECRYPT, '1, '1);
        drain();

        write_key(KEY_WORD_0, 64'h0001020304050607);
        write_key(KEY_WORD_1, 64'h08090a0b0c0d0e0f);
        write_key(KEY_WORD_2, 64'h1011121314151617);
        write_key(KEY_WORD_3, 64'h18191a1b1c1d1e1f);
        send_word(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_word(OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        send_word(OP_ENCRYPT, '1, 64'h0);
        send_word(OP_DECRYPT, 64'h0, '1);
        drain();

        for (int k = 0; k < 4; k++)
            write_key(key_idx_t'(k), '1);
        send_word(OP_ENCRYPT, 64'h0, 64'h0);
        send_word(OP_DECRYPT, '1, '1);
        drain();

        // A single word changes; the rest of the key stays.
        write_key(KEY_WORD_2, 64'h0);
        send_word(OP_ENCRYPT, 64'h8000000000000001, 64'h0123456789abcdef);
        send_word(OP_DECRYPT, 64'h8000000000000001, 64'h0123456789abcdef);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            for (int k = 0; k < 4; k++)
                if (phase == 0 || $urandom_range(0, 1))
                    write_key(key_idx_t'(k), rand64());
            for (int n = 0; n < 400; n++)
            begin
                case ($urandom_range(0, 9))
                    0: begin hi = '1; lo = rand64(); end
                    1: begin hi = rand64(); lo = 64'h0; end
                    default: begin hi = rand64(); lo = rand64(); end
                endcase
                send_word($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, hi, lo);
            end
            start <= 1'b0;
            drain();
        end

        start <= 1'b0;
        drain();
        $display("covered %0d result words over %0d key register writes", checked, key_writes);
        $display("encrypt and decrypt, field extremes, standard vector, partial key updates");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_key_exp.sv
hw/rtl/aes_col_cell.sv
hw/rtl/aes256_block_cipher.sv
tb/sv/aes_tb_pkg.sv
tb/sv/aes256_checker.sv
tb/sv/testbench.sv
